// ===== rtl/utf8_terminal_display_width_assert.svh =====
// assertion macros shared by the display width blocks
`ifndef UTF8_TERMINAL_DISPLAY_WIDTH_ASSERT_SVH
`define UTF8_TERMINAL_DISPLAY_WIDTH_ASSERT_SVH

// property checked on every rising edge outside reset
`define UTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form: when ante holds, cons holds in the same cycle
`define UTW_ASSERT_IMP(label, ante, cons, msg) \
  `UTW_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/utw_pkg.sv =====
// shared types, constants and byte classification for the display width block
package utw_pkg;

  localparam int CountBits = 24;
  localparam int ColumnW   = 24;
  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  // queue depth must stay a power of two
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] AsciiBel    = 8'h07;
  localparam logic [7:0] AsciiEsc    = 8'h1B;
  localparam logic [7:0] AsciiSpace  = 8'h20;
  localparam logic [7:0] AsciiDel    = 8'h7F;
  localparam logic [7:0] AsciiLbrack = 8'h5B;
  localparam logic [7:0] AsciiBslash = 8'h5C;
  localparam logic [7:0] AsciiRbrack = 8'h5D;
  localparam logic [7:0] CsiFinalLo  = 8'h40;
  localparam logic [7:0] CsiFinalHi  = 8'h7E;

  localparam logic [20:0] CpMin2     = 21'h000080;
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpMin4     = 21'h010000;
  localparam logic [20:0] CpSurrLo   = 21'h00D800;
  localparam logic [20:0] CpSurrHi   = 21'h00DFFF;
  localparam logic [20:0] CpMax      = 21'h10FFFF;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_CSI     = 3'd2,
    MODE_OSC     = 3'd3,
    MODE_OSC_ESC = 3'd4,
    MODE_UTF8    = 3'd5
  } mode_e;

  typedef struct packed {
    logic       is_esc;
    logic       is_bel;
    logic       is_ascii;
    logic       is_zero_w;
    logic [1:0] lead_len;
    logic       is_csi_final;
    logic       is_lbrack;
    logic       is_rbrack;
    logic       is_bslash;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } entry_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c.is_esc       = (b == AsciiEsc);
    c.is_bel       = (b == AsciiBel);
    c.is_ascii     = ~b[7];
    c.is_zero_w    = (b < AsciiSpace) || (b == AsciiDel);
    c.is_csi_final = (b >= CsiFinalLo) && (b <= CsiFinalHi);
    c.is_lbrack    = (b == AsciiLbrack);
    c.is_rbrack    = (b == AsciiRbrack);
    c.is_bslash    = (b == AsciiBslash);
    if (b[7:5] == 3'b110) begin
      c.lead_len = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      c.lead_len = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      c.lead_len = 2'd3;
    end else begin
      c.lead_len = 2'd0;
    end
    return c;
  endfunction

  // east asian wide ranges
  function automatic logic is_wide(input logic [20:0] cp);
    return (cp >= 21'h01100 && cp <= 21'h0115F) ||
           (cp >= 21'h02329 && cp <= 21'h0232A) ||
           (cp >= 21'h02E80 && cp <= 21'h0A4CF) ||
           (cp >= 21'h0AC00 && cp <= 21'h0D7A3) ||
           (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
           (cp >= 21'h0FE10 && cp <= 21'h0FE19) ||
           (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
           (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
           (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
           (cp >= 21'h20000 && cp <= 21'h2FFFD) ||
           (cp >= 21'h30000 && cp <= 21'h3FFFD);
  endfunction

endpackage

// ===== rtl/utw_if.sv =====
// valid/ready channels for string bytes and width results
interface utw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface utw_width_if;
  logic                        valid;
  logic                        ready;
  logic [utw_pkg::ColumnW-1:0] column_count;
  logic                        saturated;

  modport source (output valid, output column_count, output saturated, input ready);
  modport sink (input valid, input column_count, input saturated, output ready);
endinterface

// ===== rtl/utf8_terminal_display_width.sv =====
// Terminal display width of a UTF-8 string streamed one byte per transfer, with
// last_byte on the final byte; one result carries the saturating column count of
// the whole string. Bytes go through a classify register and a four-entry queue
// into the scanner, which takes one byte per cycle but holds on any byte while a
// result waits in the output register and the result side is not ready; so the
// block sustains one byte per cycle outside such holds and replays. The result is
// registered as the scanner takes the last byte. A sequence that fails on a bad
// continuation byte puts its buffered bytes back through the scanner (three at
// most per failing sequence); the queue takes bytes meanwhile as long as it has room.
module utf8_terminal_display_width (
  input  logic        clk_i,
  input  logic        rst_ni,
  utw_byte_if.sink    byte_i,
  utw_width_if.source width_o
);

  logic            front_valid;
  utw_pkg::entry_t front_entry;
  logic            fifo_ready;
  logic            fifo_valid;
  utw_pkg::entry_t fifo_data;
  logic            fifo_pop;

  utw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .valid_o (front_valid),
    .entry_o (front_entry),
    .ready_i (fifo_ready)
  );

  utw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_entry),
    .ready_o     (fifo_ready),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data)
  );

  utw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (fifo_valid),
    .head_i       (fifo_data),
    .head_pop_o   (fifo_pop),
    .width_o      (width_o)
  );

endmodule

// ===== rtl/utw_fifo.sv =====
// small register queue between the classify stage and the scanner
`include "utf8_terminal_display_width_assert.svh"

module utw_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utw_pkg::entry_t  push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output utw_pkg::entry_t  data_o
);

  utw_pkg::entry_t                mem_q [utw_pkg::FifoDepth];
  logic [utw_pkg::FifoAw-1:0]     wr_ptr_q, wr_ptr_d;
  logic [utw_pkg::FifoAw-1:0]     rd_ptr_q, rd_ptr_d;
  logic [utw_pkg::FifoAw:0]       cnt_q, cnt_d;
  logic                           do_push;

  assign ready_o = (cnt_q != (utw_pkg::FifoAw+1)'(utw_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (utw_pkg::FifoAw+1)'(do_push) - (utw_pkg::FifoAw+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `UTW_ASSERT_IMP(a_fifo_no_underflow, pop_i, cnt_q != '0, "pop from empty queue")

endmodule

// ===== rtl/utw_front.sv =====
// input stage: takes string bytes and tags each with its byte class
module utw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  utw_byte_if.sink          byte_i,
  output logic              valid_o,
  output utw_pkg::entry_t   entry_o,
  input  logic              ready_i
);

  logic            valid_q, valid_d;
  utw_pkg::entry_t entry_q;
  logic            take;

  assign byte_i.ready = !valid_q || ready_i;
  assign take         = byte_i.valid && byte_i.ready;
  assign valid_o      = valid_q;
  assign entry_o      = entry_q;

  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q.data <= byte_i.byte_value;
      entry_q.last <= byte_i.last_byte;
      entry_q.cls  <= utw_pkg::classify(byte_i.byte_value);
    end
  end

endmodule

// ===== rtl/utw_back.sv =====
// scanner: escape skipping, utf-8 decode, column count and result register
`include "utf8_terminal_display_width_assert.svh"

module utw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  utw_pkg::entry_t  head_i,
  output logic             head_pop_o,
  utw_width_if.source      width_o
);

  localparam int ExtW = utw_pkg::CountBits + utw_pkg::ColumnW;

  utw_pkg::mode_e                 mode_q, mode_d;
  logic [1:0]                     seq_len_q, seq_len_d;
  logic [1:0]                     br_q, br_d;
  logic [7:0]                     lead_q, lead_d;
  logic [7:0]                     pending_q [3];
  logic [7:0]                     pending_d [3];
  logic [utw_pkg::CountBits-1:0]  cnt_q, cnt_new;
  logic [7:0]                     replay_q [3];
  logic [7:0]                     replay_d [3];
  logic [1:0]                     replay_cnt_q, replay_cnt_d;
  logic                           replay_last_q, replay_last_d;
  logic                           out_valid_q, out_valid_d;
  logic [utw_pkg::ColumnW-1:0]    out_count_q;
  logic                           out_sat_q;

  logic                           from_replay;
  logic [7:0]                     src_byte;
  logic                           src_last;
  utw_pkg::byte_class_t           src_cls;
  logic [1:0]                     rest_cnt;
  logic                           final_b;
  logic                           out_free;
  logic                           step;
  logic                           res_load;

  logic [7:0]                     pend_view [3];
  logic [1:0]                     seq_n;
  logic                           bad_cont;
  logic [20:0]                    cp;
  logic [1:0]                     decode_w;
  logic [1:0]                     add_w;
  logic [1:0]                     rescan_n;
  logic [utw_pkg::CountBits:0]    sum;
  logic [ExtW-1:0]                col_ext;

  // source select: replayed bytes go ahead of the queue
  always_comb begin
    from_replay = (replay_cnt_q != 2'd0);
    src_byte    = from_replay ? replay_q[0] : head_i.data;
    src_last    = from_replay ? replay_last_q : head_i.last;
    src_cls     = from_replay ? utw_pkg::classify(replay_q[0]) : head_i.cls;
    rest_cnt    = from_replay ? replay_cnt_q - 2'd1 : 2'd0;
    final_b     = src_last && (rest_cnt == 2'd0);
    out_free    = !out_valid_q || width_o.ready;
    step        = (from_replay || head_valid_i) && out_free;
    head_pop_o  = step && !from_replay;
  end

  // decode of a complete sequence, using the byte arriving now
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pend_view[i] = (br_q == 2'(i)) ? src_byte : pending_q[i];
    end
    seq_n    = (seq_len_q == 2'd0) ? 2'd3 : seq_len_q;
    bad_cont = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < seq_n) && (pend_view[i][7:6] != 2'b10)) begin
        bad_cont = 1'b1;
      end
    end
    unique case (seq_n)
      2'd1:    cp = {10'd0, lead_q[4:0], pend_view[0][5:0]};
      2'd2:    cp = {5'd0, lead_q[3:0], pend_view[0][5:0], pend_view[1][5:0]};
      default: cp = {lead_q[2:0], pend_view[0][5:0], pend_view[1][5:0], pend_view[2][5:0]};
    endcase
    if (((seq_n == 2'd1) && (cp < utw_pkg::CpMin2)) ||
        ((seq_n == 2'd2) && (cp < utw_pkg::CpMin3)) ||
        ((seq_n == 2'd3) && (cp < utw_pkg::CpMin4)) ||
        ((cp >= utw_pkg::CpSurrLo) && (cp <= utw_pkg::CpSurrHi)) ||
        (cp > utw_pkg::CpMax)) begin
      decode_w = 2'd1;
    end else begin
      decode_w = utw_pkg::is_wide(cp) ? 2'd2 : 2'd1;
    end
  end

  // one scan step
  always_comb begin
    mode_d    = mode_q;
    seq_len_d = seq_len_q;
    br_d      = br_q;
    lead_d    = lead_q;
    pending_d = pending_q;
    add_w     = 2'd0;
    rescan_n  = 2'd0;
    unique case (mode_q)
      utw_pkg::MODE_ESC: begin
        if (src_cls.is_lbrack) begin
          mode_d = utw_pkg::MODE_CSI;
        end else if (src_cls.is_rbrack) begin
          mode_d = utw_pkg::MODE_OSC;
        end else begin
          mode_d = utw_pkg::MODE_TEXT;
        end
      end
      utw_pkg::MODE_CSI: begin
        if (src_cls.is_csi_final) begin
          mode_d = utw_pkg::MODE_TEXT;
        end
      end
      utw_pkg::MODE_OSC: begin
        if (src_cls.is_bel) begin
          mode_d = utw_pkg::MODE_TEXT;
        end else if (src_cls.is_esc) begin
          mode_d = utw_pkg::MODE_OSC_ESC;
        end
      end
      utw_pkg::MODE_OSC_ESC: begin
        if (src_cls.is_bslash || src_cls.is_bel) begin
          mode_d = utw_pkg::MODE_TEXT;
        end else if (!src_cls.is_esc) begin
          mode_d = utw_pkg::MODE_OSC;
        end
      end
      utw_pkg::MODE_UTF8: begin
        if (br_q != 2'd3) begin
          pending_d[br_q] = src_byte;
        end
        br_d = br_q + 2'd1;
        if ((br_d >= seq_len_q) || (br_d == 2'd0)) begin
          mode_d = utw_pkg::MODE_TEXT;
          add_w  = bad_cont ? 2'd1 : decode_w;
          // bad continuation: all buffered bytes are scanned again
          rescan_n = bad_cont ? seq_n : 2'd0;
        end else if (final_b) begin
          add_w  = 2'd1;
          mode_d = utw_pkg::MODE_TEXT;
        end
      end
      default: begin
        mode_d = utw_pkg::MODE_TEXT;
        if (src_cls.is_esc) begin
          mode_d = utw_pkg::MODE_ESC;
        end else if (src_cls.is_ascii) begin
          add_w = src_cls.is_zero_w ? 2'd0 : 2'd1;
        end else if (src_cls.lead_len != 2'd0) begin
          lead_d    = src_byte;
          seq_len_d = src_cls.lead_len;
          br_d      = 2'd0;
          mode_d    = utw_pkg::MODE_UTF8;
          // string ends right after a lead
          if (final_b) begin
            add_w  = 2'd1;
            mode_d = utw_pkg::MODE_TEXT;
          end
        end else begin
          add_w = 2'd1;
        end
      end
    endcase
  end

  // replay buffer: new rescan bytes go in front of what is left
  always_comb begin
    replay_d      = replay_q;
    replay_cnt_d  = replay_cnt_q;
    replay_last_d = replay_last_q;
    if (step) begin
      if (rescan_n != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < rescan_n) begin
            replay_d[i] = pend_view[i];
          end else if ((2'(i) - rescan_n) == 2'd0) begin
            replay_d[i] = replay_q[1];
          end else begin
            replay_d[i] = replay_q[2];
          end
        end
        replay_cnt_d  = rescan_n + rest_cnt;
        replay_last_d = src_last;
      end else if (from_replay) begin
        replay_d[0]  = replay_q[1];
        replay_d[1]  = replay_q[2];
        replay_cnt_d = rest_cnt;
      end
    end
  end

  // saturating column add and result formatting
  always_comb begin
    sum      = {1'b0, cnt_q} + (utw_pkg::CountBits+1)'(add_w);
    cnt_new  = sum[utw_pkg::CountBits] ? utw_pkg::CntMax : sum[utw_pkg::CountBits-1:0];
    col_ext  = {{utw_pkg::ColumnW{1'b0}}, cnt_new};
    res_load = step && final_b && (rescan_n == 2'd0);
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (width_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= utw_pkg::MODE_TEXT;
      seq_len_q     <= 2'd0;
      br_q          <= 2'd0;
      lead_q        <= 8'd0;
      cnt_q         <= '0;
      replay_cnt_q  <= 2'd0;
      replay_last_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      replay_cnt_q  <= replay_cnt_d;
      replay_last_q <= replay_last_d;
      if (res_load) begin
        mode_q    <= utw_pkg::MODE_TEXT;
        seq_len_q <= 2'd0;
        br_q      <= 2'd0;
        lead_q    <= lead_d;
        cnt_q     <= '0;
      end else if (step) begin
        mode_q    <= mode_d;
        seq_len_q <= seq_len_d;
        br_q      <= br_d;
        lead_q    <= lead_d;
        cnt_q     <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pending_q <= pending_d;
    end
    replay_q <= replay_d;
    if (res_load) begin
      out_count_q <= col_ext[utw_pkg::ColumnW-1:0];
      out_sat_q   <= (cnt_new == utw_pkg::CntMax);
    end
  end

  assign width_o.valid        = out_valid_q;
  assign width_o.column_count = out_count_q;
  assign width_o.saturated    = out_sat_q;

  `UTW_ASSERT_IMP(a_utf8_len, mode_q == utw_pkg::MODE_UTF8, seq_len_q != 2'd0, "utf8 mode without length")
  `UTW_ASSERT_IMP(a_utf8_rcv, mode_q == utw_pkg::MODE_UTF8, br_q < seq_len_q, "sequence overfilled")
  `UTW_ASSERT(a_clear_after_result, res_load |=> (cnt_q == '0 && mode_q == utw_pkg::MODE_TEXT && replay_cnt_q == 2'd0), "state not cleared after result")

endmodule
